// File: hw/rtl/nsf_pkg.sv
// Shared types and constants for the NMEA sentence framer.
`timescale 1ns / 1ps

package nsf_pkg;

    localparam int LINE_BYTES_DEF = 128;
    localparam int BYTE_W         = 8;
    localparam int LEN_W          = 7;
    localparam int HEX_W          = 4;
    localparam int S_TDATA_W      = 8;
    localparam int M_TDATA_W      = 32;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;

    // Exactly two hex digits follow the star: star, digit, digit.
    localparam int CKSUM_SPAN = 3;

    typedef enum logic [1:0] {
        ST_NONE       = 2'd0,
        ST_SENTENCE   = 2'd1,
        ST_CKSUM_ERR  = 2'd2,
        ST_OVERLENGTH = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        K_DOLLAR,
        K_CR,
        K_LF,
        K_STAR,
        K_TEXT
    } kind_t;

    // Classified character passed from front to back.
    typedef struct packed {
        kind_t             kind;
        logic              is_hex;
        logic [HEX_W-1:0]  hex_val;
        logic [BYTE_W-1:0] ch;
    } item_t;

    // Result item, lowest field last.
    typedef struct packed {
        logic [5:0]        pad;
        logic [LEN_W-1:0]  body_byte_index;
        logic              body_byte_valid;
        logic [BYTE_W-1:0] body_byte;
        logic              checksum_present;
        logic [LEN_W-1:0]  body_length;
        status_t           status;
    } result_t;

endpackage

// File: hw/rtl/nsf_front.sv
// Front end: accepts characters and classifies them.
`timescale 1ns / 1ps

module nsf_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [nsf_pkg::S_TDATA_W-1:0] s_tdata,    // [7:0] byte_in
    input  logic                          q_full,
    output logic                          q_push,
    output nsf_pkg::item_t                q_item
);
    import nsf_pkg::*;

    logic [BYTE_W-1:0] ch;

    assign ch       = s_tdata[BYTE_W-1:0];
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_item.ch      = ch;
        q_item.is_hex  = 1'b0;
        q_item.hex_val = ch[HEX_W-1:0];
        case (ch)
            CH_DOLLAR: q_item.kind = K_DOLLAR;
            CH_CR:     q_item.kind = K_CR;
            CH_LF:     q_item.kind = K_LF;
            CH_STAR:   q_item.kind = K_STAR;
            default:   q_item.kind = K_TEXT;
        endcase
        if (ch inside {[8'h30:8'h39]}) begin
            q_item.is_hex = 1'b1;
        end else if (ch inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            q_item.is_hex  = 1'b1;
            q_item.hex_val = ch[HEX_W-1:0] + 4'd9;
        end
    end

endmodule

// File: hw/rtl/nsf_queue.sv
// Two-entry queue between front and back end.
`timescale 1ns / 1ps

module nsf_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  nsf_pkg::item_t wr_item,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output nsf_pkg::item_t rd_item
);
    import nsf_pkg::*;

    item_t      head_reg, head_next;
    item_t      tail_reg, tail_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign rd_item   = head_reg;

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        case ({push, pop})
            2'b10: begin
                if (cnt_reg == 2'd0) begin
                    head_next = wr_item;
                end else begin
                    tail_next = wr_item;
                end
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01: begin
                head_next = tail_reg;
                cnt_next  = cnt_reg - 2'd1;
            end
            2'b11: begin
                if (cnt_reg == 2'd1) begin
                    head_next = wr_item;
                end else begin
                    head_next = tail_reg;
                    tail_next = wr_item;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

// File: hw/rtl/nsf_back.sv
// Back end: sentence state, checksum check and result register.
`timescale 1ns / 1ps

module nsf_back #(
    parameter int LINE_BYTES = nsf_pkg::LINE_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  nsf_pkg::item_t                q_item,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [nsf_pkg::M_TDATA_W-1:0] m_tdata
);
    import nsf_pkg::*;

    localparam int CW = $clog2(LINE_BYTES);
    localparam logic [CW-1:0] CNT_LIM = CW'(LINE_BYTES - 1);

    logic              in_s_reg,   in_s_next;
    logic [CW-1:0]     cnt_reg,    cnt_next;
    logic              star_reg,   star_next;
    logic [CW-1:0]     spos_reg,   spos_next;
    logic [BYTE_W-1:0] xor_reg,    xor_next;
    logic [BYTE_W-1:0] rsum_reg,   rsum_next;
    logic              hexok_reg,  hexok_next;
    logic [LEN_W-1:0]  len_reg,    len_next;
    logic              ck_reg,     ck_next;
    logic              mvalid_reg, mvalid_next;
    result_t           res_reg,    res_next;

    logic              out_ready;
    logic [CW-1:0]     diff;
    logic [CW-1:0]     body;
    status_t           status;
    logic [BYTE_W-1:0] bb;
    logic              bv;
    logic [LEN_W-1:0]  bi;

    assign out_ready = !mvalid_reg || m_tready;
    assign q_pop     = q_valid && out_ready;
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = res_reg;
    assign diff      = cnt_reg - spos_reg;

    always_comb begin
        in_s_next  = in_s_reg;
        cnt_next   = cnt_reg;
        star_next  = star_reg;
        spos_next  = spos_reg;
        xor_next   = xor_reg;
        rsum_next  = rsum_reg;
        hexok_next = hexok_reg;
        len_next   = len_reg;
        ck_next    = ck_reg;
        status     = ST_NONE;
        bb         = '0;
        bv         = 1'b0;
        bi         = '0;
        body       = cnt_reg;
        if (q_pop) begin
            if (q_item.kind == K_DOLLAR) begin
                in_s_next  = 1'b1;
                cnt_next   = '0;
                star_next  = 1'b0;
                spos_next  = '0;
                xor_next   = '0;
                rsum_next  = '0;
                hexok_next = 1'b1;
            end else if (!in_s_reg || q_item.kind == K_CR) begin
            end else if (q_item.kind == K_LF) begin
                in_s_next = 1'b0;
                ck_next   = 1'b0;
                if (star_reg && (diff != CW'(CKSUM_SPAN) || !hexok_reg ||
                                 rsum_reg != xor_reg)) begin
                    status = ST_CKSUM_ERR;
                end else begin
                    if (star_reg) begin
                        ck_next = 1'b1;
                        body    = spos_reg;
                    end
                    len_next = LEN_W'(body);
                    status   = (body != '0) ? ST_SENTENCE : ST_NONE;
                end
            end else if (cnt_reg >= CNT_LIM) begin
                in_s_next  = 1'b0;
                cnt_next   = '0;
                star_next  = 1'b0;
                spos_next  = '0;
                xor_next   = '0;
                rsum_next  = '0;
                hexok_next = 1'b1;
                len_next   = '0;
                ck_next    = 1'b0;
                status     = ST_OVERLENGTH;
            end else begin
                if (!star_reg) begin
                    if (q_item.kind == K_STAR) begin
                        star_next = 1'b1;
                        spos_next = cnt_reg;
                    end else begin
                        xor_next = xor_reg ^ q_item.ch;
                        bb       = q_item.ch;
                        bv       = 1'b1;
                        bi       = LEN_W'(cnt_reg);
                    end
                end else if (!q_item.is_hex) begin
                    hexok_next = 1'b0;
                end else if (diff <= CW'(2)) begin
                    rsum_next = {rsum_reg[HEX_W-1:0], q_item.hex_val};
                end
                cnt_next = cnt_reg + CW'(1);
            end
        end
        res_next                  = res_reg;
        mvalid_next               = mvalid_reg;
        if (out_ready) begin
            mvalid_next = q_pop;
        end
        if (q_pop) begin
            res_next.pad              = '0;
            res_next.status           = status;
            res_next.body_length      = len_next;
            res_next.checksum_present = ck_next;
            res_next.body_byte        = bb;
            res_next.body_byte_valid  = bv;
            res_next.body_byte_index  = bi;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_s_reg   <= 1'b0;
            cnt_reg    <= '0;
            star_reg   <= 1'b0;
            spos_reg   <= '0;
            xor_reg    <= '0;
            rsum_reg   <= '0;
            hexok_reg  <= 1'b1;
            len_reg    <= '0;
            ck_reg     <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            in_s_reg   <= in_s_next;
            cnt_reg    <= cnt_next;
            star_reg   <= star_next;
            spos_reg   <= spos_next;
            xor_reg    <= xor_next;
            rsum_reg   <= rsum_next;
            hexok_reg  <= hexok_next;
            len_reg    <= len_next;
            ck_reg     <= ck_next;
            mvalid_reg <= mvalid_next;
        end
        res_reg <= res_next;
    end

`ifndef SYNTHESIS
    a_body_no_status: assert property (@(posedge aclk) disable iff (!aresetn)
        mvalid_reg && res_reg.body_byte_valid |-> res_reg.status == ST_NONE)
        else $error("body item carries a line status");

    a_star_before_count: assert property (@(posedge aclk) disable iff (!aresetn)
        star_reg |-> spos_reg < cnt_reg)
        else $error("star position not below character count");

    a_overlength_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        mvalid_reg && res_reg.status == ST_OVERLENGTH |->
            res_reg.body_length == '0 && !res_reg.checksum_present)
        else $error("overlength left stale line summary");
`endif

endmodule

// File: hw/rtl/nmea_sentence_framer.sv
// Top level of the NMEA sentence framer.
//
// Usage: one received character per input item on s_tdata[7:0]. Every
// accepted character gives exactly one result item on m_tdata, carrying
// the line status (none, sentence, checksum error, overlength), the last
// finished body length and checksum flag, and, for body characters before
// the star, the character and its index for an outside line store.
// Path: a character is classified as it is written into the queue, and the
// line state and the result register are updated as it leaves the queue.
// Throughput: one item per cycle while m_tready is high or no result waits,
// set by the state update in the back end; the two-entry queue lets the
// front keep accepting while the result register waits.
// When m_tready is low the result register holds, the queue fills and
// s_tready drops once it holds two items.
// Reset (aresetn low, synchronous) empties the queue and the result
// register and returns to outside-a-sentence with an empty line summary.
`timescale 1ns / 1ps

module nmea_sentence_framer #(
    parameter int LINE_BYTES = nsf_pkg::LINE_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [nsf_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] byte_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [1:0] status, [8:2] body_length, [9] checksum_present,
    // [17:10] body_byte, [18] body_byte_valid, [25:19] body_byte_index
    output logic [nsf_pkg::M_TDATA_W-1:0] m_tdata
);
    import nsf_pkg::*;

    item_t push_item;
    item_t head_item;
    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_not_empty;

    nsf_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    nsf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .wr_item   (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rd_item   (head_item)
    );

    nsf_back #(
        .LINE_BYTES (LINE_BYTES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_not_empty),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
